### hdl/distinct_random_pick_bitmap_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the distinct random picker
// Clocked concurrent checks, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef DISTINCT_RANDOM_PICK_BITMAP_TOP_ASSERT_SVH
`define DISTINCT_RANDOM_PICK_BITMAP_TOP_ASSERT_SVH

// Property that must hold at every edge.
`define DRPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define DRPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/drpb_pkg.sv
// ---------------------------------------------------------------------------
// drpb_pkg
// Shared types and constants of the distinct random picker.
// ---------------------------------------------------------------------------
package drpb_pkg;

  // default bitmap depth (values per run window)
  localparam int SPAN_DEF = 4096;

  // bitmap memory row geometry
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  // field widths
  localparam int VAL_W   = 16;
  localparam int RND_W   = 32;
  localparam int CNT_W   = 13;
  localparam int CMD_W   = 2;
  localparam int MOD_W   = VAL_W + 1;
  localparam int CFG_IW  = 2;
  localparam int IN_DW   = VAL_W + RND_W;
  localparam int OUT_DW  = 1 + VAL_W + CNT_W + 1 + 1;

  // register reset values
  localparam logic [VAL_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 16'd4096;
  localparam logic [CNT_W-1:0] PICK_COUNT_RST = 13'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_EXCLUDE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_DRAW    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_PICK_COUNT = 2'd2
  } cfg_idx_t;

endpackage

### hdl/distinct_random_pick_bitmap_top.sv
// ---------------------------------------------------------------------------
// distinct_random_pick_bitmap_top
// Draws distinct values from [range_low, range_high) using a used-value
// bitmap held in a row-organized synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one command item per handshake. in_tuser = cmd, in_tdata holds
//           value and random_word. Items are taken one at a time.
//   out_* : exactly one result item per command item, in order.
//   cfg_* : register writes (index 0 low, 1 high, 2 pick count), always
//           ready; write only while the block is idle.
// Steps (accept to result valid, receiver ready):
//   draw that runs      : 32-step restoring remainder (one quotient bit per
//                         cycle), then add, lookup and a read-modify-write that is
//                         skipped when the candidate falls outside the window
//   exclude / release   : bitmap read, then write back; neither if ignored
//   refused draw        : straight to the result
//   restart             : clear of all ROWS rows, ROWS = ceil(SPAN/32) (128 default)
// Item flow: the next item is taken in the cycle after the result is loaded;
//   no new item is taken while one is still being worked on.
// Reset: control and config registers return to defaults and the bitmap is
//   cleared by a pass over its ROWS rows (128 at SPAN = 4096), one 32-bit row
//   per cycle; in_tready stays low during the pass, cfg writes are still taken.
// Stall: the result register holds while out_tready is low; the next item is
//   accepted and worked on, and waits at its final step for the slot.
// ---------------------------------------------------------------------------
`include "distinct_random_pick_bitmap_top_assert.svh"

module distinct_random_pick_bitmap_top
  import drpb_pkg::*;
#(
  parameter int SPAN = SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // command items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [15:0] value, [47:16] random_word
  input  logic [CMD_W-1:0]  in_tuser,   // [1:0] cmd
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [0] accepted, [16:1] picked_value,
                                        // [29:17] drawn_count, [30] done_res,
                                        // [31] config_error
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  localparam int ROWS   = (SPAN + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int STEP_W = $clog2(RND_W);
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(RND_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,  // zero the bitmap, one row per cycle
    ST_IDLE,   // wait for a command item
    ST_DIV,    // remainder, one bit per cycle
    ST_SUM,    // candidate = low + remainder
    ST_LOOK,   // range check, issue bitmap row read
    ST_RDW,    // modify row and write back
    ST_FIN     // hand result to output register
  } state_t;

  // bitmap memory
  logic [ROW_W-1:0] map_mem [ROWS];
  logic [ROW_W-1:0] rd_row_r;
  logic              mem_we, mem_re;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  // control and payload registers
  state_t            state_r, state_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic              clr_item_r, clr_item_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [VAL_W-1:0]  cand_r, cand_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  mod_r, mod_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              bad_r, bad_nxt;
  logic              acc_r, acc_nxt;
  logic [VAL_W-1:0]  pick_r, pick_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [VAL_W-1:0]  lo_r, lo_nxt;
  logic [VAL_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  // combinational helpers
  logic              in_accept;
  cmd_t              in_cmd;
  logic              cfg_bad;
  logic [MOD_W-1:0]  span_w;
  logic [VAL_W-1:0]  cand_off;
  logic              cand_hit;
  logic [ROW_AW-1:0] cand_row;
  logic [ROW_BW-1:0] cand_bit;
  logic [ROW_W-1:0]  cand_mask;
  logic [MOD_W:0]    trial;
  logic              slot_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_tvalid_r || out_tready;

  // configuration check: empty range, count too big, span beyond bitmap
  assign span_w  = {1'b0, hi_r} - {1'b0, lo_r};
  assign cfg_bad = (lo_r >= hi_r) || ({4'b0, cnt_r} > span_w)
                   || (span_w > MOD_W'(SPAN));

  // candidate mapping onto the bitmap
  assign cand_off  = cand_r - lo_r;
  assign cand_hit  = (cand_r >= lo_r) && (cand_r < hi_r)
                     && ({1'b0, cand_off} < MOD_W'(SPAN));
  assign cand_row  = ROW_AW'(cand_off >> ROW_BW);
  assign cand_bit  = cand_off[ROW_BW-1:0];
  assign cand_mask = {{(ROW_W-1){1'b0}}, 1'b1} << cand_bit;

  // one restoring-remainder step
  assign trial = {rem_r, rnd_r[RND_W-1]};

  always_comb begin
    state_nxt      = state_r;
    clr_row_nxt    = clr_row_r;
    clr_item_nxt   = clr_item_r;
    cmd_nxt        = cmd_r;
    cand_nxt       = cand_r;
    rnd_nxt        = rnd_r;
    rem_nxt        = rem_r;
    mod_nxt        = mod_r;
    step_nxt       = step_r;
    bad_nxt        = bad_r;
    acc_nxt        = acc_r;
    pick_nxt       = pick_r;
    total_nxt      = total_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = cand_row;
    mem_wdata      = rd_row_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE_LOW:  lo_nxt  = cfg_data;
        CFG_RANGE_HIGH: hi_nxt  = cfg_data;
        CFG_PICK_COUNT: cnt_nxt = cfg_data[CNT_W-1:0];
        default: ;  // index beyond the list: ignored
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_r;
        mem_wdata = '0;
        if (clr_row_r == ROW_LAST) begin
          clr_row_nxt = '0;
          state_nxt   = clr_item_r ? ST_FIN : ST_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt  = in_cmd;
          cand_nxt = in_tdata[VAL_W-1:0];
          rnd_nxt  = in_tdata[IN_DW-1:VAL_W];
          rem_nxt  = '0;
          step_nxt = '0;
          mod_nxt  = span_w + 1'b1;
          bad_nxt  = cfg_bad;
          acc_nxt  = 1'b0;
          pick_nxt = '0;
          case (in_cmd)
            CMD_EXCLUDE, CMD_RELEASE: state_nxt = ST_LOOK;
            CMD_DRAW: begin
              state_nxt = (!cfg_bad && (total_r < cnt_r)) ? ST_DIV : ST_FIN;
            end
            CMD_RESTART: begin
              total_nxt    = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, mod_r}) begin
          rem_nxt = MOD_W'(trial - {1'b0, mod_r});
        end else begin
          rem_nxt = trial[MOD_W-1:0];
        end
        rnd_nxt  = {rnd_r[RND_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // rem < high - low + 1, so the sum stays within 16 bits
        cand_nxt  = VAL_W'({1'b0, lo_r} + rem_r);
        pick_nxt  = VAL_W'({1'b0, lo_r} + rem_r);
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (cand_hit) begin
          mem_re    = 1'b1;
          state_nxt = ST_RDW;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_RDW: begin
        case (cmd_r)
          CMD_EXCLUDE: begin
            mem_we    = 1'b1;
            mem_wdata = rd_row_r | cand_mask;
          end
          CMD_RELEASE: begin
            mem_we    = 1'b1;
            mem_wdata = rd_row_r & ~cand_mask;
          end
          CMD_DRAW: begin
            if (!rd_row_r[cand_bit]) begin
              mem_we    = 1'b1;
              mem_wdata = rd_row_r | cand_mask;
              acc_nxt   = 1'b1;
              total_nxt = total_r + 1'b1;
            end
          end
          default: ;
        endcase
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {bad_r, (total_r >= cnt_r), total_r, pick_r, acc_r};
          clr_item_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_row_r    <= '0;
      clr_item_r   <= 1'b0;
      total_r      <= '0;
      lo_r         <= RANGE_LOW_RST;
      hi_r         <= RANGE_HIGH_RST;
      cnt_r        <= PICK_COUNT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_row_r    <= clr_row_nxt;
      clr_item_r   <= clr_item_nxt;
      total_r      <= total_nxt;
      lo_r         <= lo_nxt;
      hi_r         <= hi_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r      <= cmd_nxt;
    cand_r     <= cand_nxt;
    rnd_r      <= rnd_nxt;
    rem_r      <= rem_nxt;
    mod_r      <= mod_nxt;
    step_r     <= step_nxt;
    bad_r      <= bad_nxt;
    acc_r      <= acc_nxt;
    pick_r     <= pick_nxt;
    out_data_r <= out_data_nxt;
  end

  // bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= map_mem[cand_row];
    end
  end

  // read and write of a row are sequenced, never in the same cycle
  `DRPB_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && mem_re), "bitmap read and write overlap")
  `DRPB_ASSERT_ALWAYS(a_no_accept_in_clear, !((state_r == ST_CLEAR) && in_tready), "ready during clear")
  `DRPB_ASSERT_NEXT(a_count_step, (state_r == ST_RDW) && (cmd_r == CMD_DRAW) && mem_we, total_r == CNT_W'($past(total_r) + 1'b1), "accepted draw not counted")
  `DRPB_ASSERT_NEXT(a_fin_holds, (state_r == ST_FIN) && out_tvalid_r && !out_tready, state_r == ST_FIN, "result lost while output stalled")

endmodule
